[sv/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a property holds on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assert that an implication holds on every clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`endif

[sv/hmdp_pkg.sv]
// package of types and constants for the hid mouse descriptor parser
package hmdp_pkg;
  localparam int unsigned MaxLocalUsages = 16;
  localparam int unsigned UsageIdxW = $clog2(MaxLocalUsages);
  localparam int unsigned UsageFillW = $clog2(MaxLocalUsages + 1);

  localparam logic [7:0] LongPrefix = 8'hFE;
  localparam logic [7:0] TagUsagePage = 8'h04;
  localparam logic [7:0] TagUsage = 8'h08;
  localparam logic [7:0] TagReportSize = 8'h74;
  localparam logic [7:0] TagReportId = 8'h84;
  localparam logic [7:0] TagReportCount = 8'h94;
  localparam logic [7:0] TagInput = 8'h80;
  localparam logic [31:0] PageButton = 32'h09;
  localparam logic [31:0] PageDesktop = 32'h01;
  localparam logic [31:0] UsageX = 32'h30;
  localparam logic [31:0] UsageY = 32'h31;

  typedef struct packed {
    logic [7:0] desc_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        found_valid;
    logic [7:0]  report_ident;
    logic [15:0] button_pos;
    logic [7:0]  button_num;
    logic [15:0] x_pos;
    logic [7:0]  x_width;
    logic [15:0] y_pos;
    logic [7:0]  y_width;
    logic [15:0] total_width;
  } out_t;
endpackage

[sv/hid_mouse_descriptor_parser.sv]
// top level of the hid mouse descriptor parser
// Usage:
// - in channel (in_valid_i/in_ready_o/in_data_i) takes one descriptor byte per
//   transaction, with last_byte marking the final byte of a descriptor
// - out channel (out_valid_o/out_ready_i/out_data_o) gives one result per
//   descriptor, after the transaction carrying last_byte
// - data bytes and long-item bytes are taken in the idle state; a byte that
//   completes a short item then passes through the execute step, and one that
//   completes an Input item through the execute and grow steps, with walk
//   steps between them when the stored usages are walked on the Generic Desktop
//   page: at most 16 usages, one per cycle through a shared compare and add unit
// - the offset growth size * count comes from one multiplier used in the
//   last step of an Input item
// - a last byte then passes through the emit step to form the result, which then
//   sits in the output register; the next byte is accepted while it waits
// - a further last byte is held off until the earlier result is taken
// - reset clears all parse state and the output register; the usage store
//   holds undefined data that is never read before being written
// - after each result all state but the walk index and bit position returns to its reset values
module hid_mouse_descriptor_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hmdp_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hmdp_pkg::out_t  out_data_o
);
  localparam logic [1:0] PhPrefix = 2'd0;
  localparam logic [1:0] PhLongLen = 2'd1;
  localparam logic [1:0] PhSkip = 2'd2;
  localparam logic [1:0] PhData = 2'd3;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExec = 3'd1;
  localparam logic [2:0] StWalk = 3'd2;
  localparam logic [2:0] StGrow = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0] st_q, st_d;
  logic [1:0] ph_q, ph_d;
  logic [7:0] prefix_q, prefix_d;
  logic [8:0] left_q, left_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] page_q, page_d, size_q, size_d, count_q, count_d, offs_q, offs_d;
  logic [hmdp_pkg::UsageFillW-1:0] fill_q, fill_d;
  logic fx_q, fx_d, fy_q, fy_d, fb_q, fb_d;
  logic [7:0] ident_q, ident_d, bnum_q, bnum_d, xw_q, xw_d, yw_q, yw_d;
  logic [15:0] bpos_q, bpos_d, xpos_q, xpos_d, ypos_q, ypos_d;
  logic last_q, last_d;
  logic [hmdp_pkg::UsageFillW-1:0] idx_q, idx_d;
  logic [31:0] bit_q, bit_d;
  logic [31:0] usage_mem [hmdp_pkg::MaxLocalUsages];
  logic [31:0] rd_q;
  logic mem_we;
  logic [hmdp_pkg::UsageIdxW-1:0] mem_wa, mem_ra;
  logic out_valid_q;
  hmdp_pkg::out_t out_q;
  logic emit;
  logic accept;
  logic [31:0] prod;
  logic [31:0] acc_new;
  logic [2:0] isz;
  logic [1:0] pos;

  assign in_ready_o = (st_q == StIdle) && !(in_data_i.last_byte && out_valid_q);
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  // multiplier for offset growth, used in the grow step
  assign prod = size_q * count_q;

  // usage store, written on usage items, read one entry per walk step
  always_ff @(posedge clk_i) begin
    if (mem_we) usage_mem[mem_wa] <= acc_q;
    rd_q <= usage_mem[mem_ra];
  end

  always_comb begin
    isz = (in_data_i.desc_byte[1:0] == 2'd3) ? 3'd4 : {1'b0, in_data_i.desc_byte[1:0]};
    pos = 2'((prefix_q[1:0] == 2'd3 ? 9'd4 : {7'd0, prefix_q[1:0]}) - left_q);
    acc_new = acc_q | ({24'd0, in_data_i.desc_byte} << {pos, 3'd0});
  end

  always_comb begin
    st_d = st_q; ph_d = ph_q; prefix_d = prefix_q; left_d = left_q; acc_d = acc_q;
    page_d = page_q; size_d = size_q; count_d = count_q; offs_d = offs_q;
    fill_d = fill_q; fx_d = fx_q; fy_d = fy_q; fb_d = fb_q;
    ident_d = ident_q; bnum_d = bnum_q; xw_d = xw_q; yw_d = yw_q;
    bpos_d = bpos_q; xpos_d = xpos_q; ypos_d = ypos_q;
    last_d = last_q; idx_d = idx_q; bit_d = bit_q;
    mem_we = 1'b0; mem_wa = fill_q[hmdp_pkg::UsageIdxW-1:0];
    mem_ra = idx_q[hmdp_pkg::UsageIdxW-1:0];
    emit = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (accept) begin
          last_d = in_data_i.last_byte;
          st_d = in_data_i.last_byte ? StEmit : StIdle;
          unique case (ph_q)
            PhPrefix: begin
              if (in_data_i.desc_byte == hmdp_pkg::LongPrefix) begin
                ph_d = PhLongLen;
              end else begin
                prefix_d = in_data_i.desc_byte;
                acc_d = '0;
                left_d = {6'd0, isz};
                if (isz == 3'd0) st_d = StExec;
                else ph_d = PhData;
              end
            end
            PhLongLen: begin
              left_d = 9'd1 + {1'b0, in_data_i.desc_byte};
              ph_d = PhSkip;
            end
            PhSkip: begin
              if (left_q <= 9'd1) ph_d = PhPrefix;
              if (left_q != 9'd0) left_d = left_q - 9'd1;
            end
            PhData: begin
              acc_d = acc_new;
              if (left_q <= 9'd1) begin
                st_d = StExec;
                ph_d = PhPrefix;
              end
              if (left_q != 9'd0) left_d = left_q - 9'd1;
            end
            default: ;
          endcase
        end
      end
      StExec: begin
        st_d = last_q ? StEmit : StIdle;
        case (prefix_q & 8'hFC)
          hmdp_pkg::TagUsagePage: page_d = acc_q;
          hmdp_pkg::TagUsage: begin
            if (fill_q < hmdp_pkg::UsageFillW'(hmdp_pkg::MaxLocalUsages)) begin
              mem_we = 1'b1;
              fill_d = fill_q + 1'b1;
            end
          end
          hmdp_pkg::TagReportSize: size_d = acc_q;
          hmdp_pkg::TagReportCount: count_d = acc_q;
          hmdp_pkg::TagReportId: begin
            if (!(fx_q && fy_q)) begin
              ident_d = acc_q[7:0]; offs_d = '0; fb_d = 1'b0;
              bpos_d = '0; bnum_d = '0;
            end
          end
          hmdp_pkg::TagInput: begin
            bit_d = offs_q;
            idx_d = '0;
            st_d = StGrow;
            if (!acc_q[0] && size_q != 0 && count_q != 0) begin
              if (page_q == hmdp_pkg::PageButton && !fb_q) begin
                fb_d = 1'b1; bpos_d = offs_q[15:0]; bnum_d = count_q[7:0];
              end else if (page_q == hmdp_pkg::PageDesktop && fill_q != 0) begin
                st_d = StWalk;
              end
            end
          end
          default: ;
        endcase
        if (prefix_q[3:2] == 2'd0 && (prefix_q & 8'hFC) != hmdp_pkg::TagInput)
          fill_d = '0;
      end
      StWalk: begin
        // rd_q holds entry idx_q-1 once idx_q is nonzero
        mem_ra = idx_q[hmdp_pkg::UsageIdxW-1:0];
        if (idx_q != 0) begin
          if (rd_q == hmdp_pkg::UsageX && !fx_q) begin
            fx_d = 1'b1; xpos_d = bit_q[15:0]; xw_d = size_q[7:0];
          end else if (rd_q == hmdp_pkg::UsageY && !fy_q) begin
            fy_d = 1'b1; ypos_d = bit_q[15:0]; yw_d = size_q[7:0];
          end
          bit_d = bit_q + size_q;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == fill_q || 32'(idx_q) == count_q) st_d = StGrow;
      end
      StGrow: begin
        offs_d = offs_q + prod;
        fill_d = '0;
        st_d = last_q ? StEmit : StIdle;
      end
      StEmit: begin
        emit = 1'b1;
        st_d = StIdle; ph_d = PhPrefix; prefix_d = '0; left_d = '0; acc_d = '0;
        page_d = '0; size_d = '0; count_d = '0; offs_d = '0; fill_d = '0;
        fx_d = 1'b0; fy_d = 1'b0; fb_d = 1'b0;
        ident_d = '0; bnum_d = '0; xw_d = '0; yw_d = '0;
        bpos_d = '0; xpos_d = '0; ypos_d = '0; last_d = 1'b0;
      end
      default: st_d = StIdle;
    endcase
  end

  // control and layout state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ph_q <= PhPrefix; prefix_q <= '0; left_q <= '0; acc_q <= '0;
      page_q <= '0; size_q <= '0; count_q <= '0; offs_q <= '0; fill_q <= '0;
      fx_q <= 1'b0; fy_q <= 1'b0; fb_q <= 1'b0;
      ident_q <= '0; bnum_q <= '0; xw_q <= '0; yw_q <= '0;
      bpos_q <= '0; xpos_q <= '0; ypos_q <= '0; last_q <= 1'b0;
      idx_q <= '0; bit_q <= '0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; prefix_q <= prefix_d; left_q <= left_d; acc_q <= acc_d;
      page_q <= page_d; size_q <= size_d; count_q <= count_d; offs_q <= offs_d;
      fill_q <= fill_d; fx_q <= fx_d; fy_q <= fy_d; fb_q <= fb_d;
      ident_q <= ident_d; bnum_q <= bnum_d; xw_q <= xw_d; yw_q <= yw_d;
      bpos_q <= bpos_d; xpos_q <= xpos_d; ypos_q <= ypos_d; last_q <= last_d;
      idx_q <= idx_d; bit_q <= bit_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q <= '0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
      if (fx_q && fy_q) begin
        out_q <= '{1'b1, ident_q, bpos_q, bnum_q, xpos_q, xw_q, ypos_q, yw_q, offs_q[15:0]};
      end else begin
        out_q <= '0;
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end
endmodule

[sv/hmdp_checker.sv]
// port-level checker for the hid mouse descriptor parser, with its bind
`include "assert_macros.svh"
module hmdp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input hmdp_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input hmdp_pkg::out_t out_data_o
);
  `ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, ##1 (out_valid_o && $stable(out_data_o)), "result dropped while stalled")
  `ASSERT_IMP(a_no_result_data, clk_i, rst_ni, out_valid_o && !out_data_o.found_valid, out_data_o == '0, "fields not zero without found")
  `ASSERT_IMP(a_last_gap, clk_i, rst_ni, in_valid_i && in_ready_o && in_data_i.last_byte, ##1 !in_ready_o, "ready right after last byte")
  `ASSERT_IMP(a_no_stack, clk_i, rst_ni, out_valid_o && !out_ready_i && in_data_i.last_byte, !in_ready_o, "second result while one waits")
endmodule

bind hid_mouse_descriptor_parser hmdp_checker u_hmdp_checker (.*);
